/* src/pebu_pkg.sv */
// Shared types, codes and arithmetic helpers for the pixel effect and blend unit.
package pebu_pkg;

  localparam int CH_W      = 8;
  localparam int PIX_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;
  localparam int TCH_W     = 2;
  localparam int TONE_DEPTH = 256;

  localparam logic [CH_W-1:0] CH_MAX = 8'hFF;

  // grey weights and reciprocal of 1000 (exact for sums up to 255*1000)
  localparam logic [17:0] GREY_WR     = 18'd299;
  localparam logic [17:0] GREY_WG     = 18'd587;
  localparam logic [17:0] GREY_WB     = 18'd114;
  localparam logic [18:0] GREY_RECIP  = 19'd268436;
  localparam int          GREY_SHIFT  = 28;
  localparam int          GREY_PROD_W = 37;

  typedef enum logic [2:0] {
    MODE_FILL   = 3'd0,
    MODE_INVERT = 3'd1,
    MODE_GREY   = 3'd2,
    MODE_TINT   = 3'd3,
    MODE_TONE   = 3'd4,
    MODE_BLEND  = 3'd5
  } mode_t;

  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OP_COLOUR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_A   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_USE_SA    = 3'd3;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_TABLE = 1'b1;

  localparam logic [TCH_W-1:0] TCH_RED   = 2'd0;
  localparam logic [TCH_W-1:0] TCH_GREEN = 2'd1;
  localparam logic [TCH_W-1:0] TCH_BLUE  = 2'd2;

  typedef struct packed {
    logic [2:0]       mode;
    logic [PIX_W-1:0] op_colour;
    logic [CH_W-1:0]  blend_alpha;
    logic             use_source_alpha;
  } pebu_cfg_t;

  // register load strobes for each pipeline stage
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic so;
  } pebu_stage_ld_t;

  // x / 255 for x <= 255*255
  function automatic logic [CH_W-1:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
    return t[15:8];
  endfunction

  function automatic logic [PIX_W-1:0] pack_px(input logic [CH_W-1:0] r,
                                               input logic [CH_W-1:0] g,
                                               input logic [CH_W-1:0] b,
                                               input logic [CH_W-1:0] a);
    return {a, b, g, r};
  endfunction

endpackage

/* src/pixel_effect_and_blend_unit.sv */
// Pixel effect and blend unit: configuration, tone table banks, pipeline control.
//
// Takes one transaction per clock while in_ready is high and returns one result per
// transaction, in order. The transaction is registered on acceptance and moves through
// four arithmetic stages (products, divide-by-255 and grey reciprocal, blend lane
// products, blend finish), the last of which loads the output register. Each stage
// holds independently when the one after it is full, so input stays ready while a
// result waits as long as a stage has room.
// The tone table is three 256-entry banks, one per colour channel, written and read in
// the cycle a transaction is accepted; it has no clearing pass, and a pixel must not
// look up an entry that was never loaded. Configuration writes must only be made while
// no pixel is in flight.
module pixel_effect_and_blend_unit import pebu_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_opcode,
  input  logic [PIX_W-1:0]     in_pixel,
  input  logic [PIX_W-1:0]     in_dest_pixel,
  input  logic [TCH_W-1:0]     in_table_channel,
  input  logic [CH_W-1:0]      in_table_index,
  input  logic [CH_W-1:0]      in_table_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [PIX_W-1:0]     out_pixel,
  output logic                 out_write_enable,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  pebu_cfg_t      cfg_r, cfg_nxt;
  logic [3:0]     v_r, v_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [4:0]     free;
  logic           in_acc;
  pebu_stage_ld_t ld;
  logic [2:0]     tone_we;
  logic           tone_re;
  logic [CH_W-1:0] tone_rd [3];

  // configuration
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_MODE:      cfg_nxt.mode             = cfg_data[2:0];
        REG_OP_COLOUR: cfg_nxt.op_colour        = cfg_data[PIX_W-1:0];
        REG_BLEND_A:   cfg_nxt.blend_alpha      = cfg_data[CH_W-1:0];
        REG_USE_SA:    cfg_nxt.use_source_alpha = cfg_data[0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode             <= MODE_FILL;
      cfg_r.op_colour        <= '0;
      cfg_r.blend_alpha      <= CH_MAX;
      cfg_r.use_source_alpha <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // pipeline occupancy: a stage takes new data when empty or when it moves on
  always_comb begin
    free[4] = !out_valid_r || out_ready;
    free[3] = !v_r[3] || free[4];
    free[2] = !v_r[2] || free[3];
    free[1] = !v_r[1] || free[2];
    free[0] = !v_r[0] || free[1];
    in_acc  = in_valid && free[0];

    v_nxt[0]      = free[0] ? in_valid : v_r[0];
    v_nxt[1]      = free[1] ? v_r[0]   : v_r[1];
    v_nxt[2]      = free[2] ? v_r[1]   : v_r[2];
    v_nxt[3]      = free[3] ? v_r[2]   : v_r[3];
    out_valid_nxt = free[4] ? v_r[3]   : out_valid_r;

    ld.s1 = in_acc;
    ld.s2 = free[1] && v_r[0];
    ld.s3 = free[2] && v_r[1];
    ld.s4 = free[3] && v_r[2];
    ld.so = free[4] && v_r[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      v_r         <= v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = free[0];
  assign out_valid = out_valid_r;

  // tone table banks; channel 3 loads are dropped
  always_comb begin
    tone_we = '0;
    if (in_acc && in_opcode == OP_TABLE) begin
      case (in_table_channel)
        TCH_RED:   tone_we = 3'b001;
        TCH_GREEN: tone_we = 3'b010;
        TCH_BLUE:  tone_we = 3'b100;
        default:   tone_we = '0;
      endcase
    end
    tone_re = in_acc && in_opcode == OP_PIXEL;
  end

  for (genvar k = 0; k < 3; k++) begin : g_tone
    pebu_ram #(
      .WIDTH (CH_W),
      .DEPTH (TONE_DEPTH)
    ) u_tone (
      .clk   (clk),
      .we    (tone_we[k]),
      .waddr (in_table_index),
      .wdata (in_table_value),
      .re    (tone_re),
      .raddr (in_pixel[8*k +: 8]),
      .rdata (tone_rd[k])
    );
  end

  pebu_pipe u_pipe (
    .clk              (clk),
    .ld               (ld),
    .cfg              (cfg_r),
    .in_opcode        (in_opcode),
    .in_pixel         (in_pixel),
    .in_dest_pixel    (in_dest_pixel),
    .tone_r           (tone_rd[0]),
    .tone_g           (tone_rd[1]),
    .tone_b           (tone_rd[2]),
    .out_pixel        (out_pixel),
    .out_write_enable (out_write_enable)
  );

  // input stalls only when every stage is full and the output is held
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&v_r && out_valid_r && !out_ready))
    else $error("input stalled with room in the pipeline");

  a_tone_port: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tone_we) && !((tone_we != 3'b000) && tone_re))
    else $error("tone table written and read by one transaction");

  a_out_from_s4: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(v_r[3]))
    else $error("result raised without a transaction in the last stage");

  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !v_r[0]) |=> v_r[0])
    else $error("accepted transaction lost at the first stage");

endmodule

/* src/pebu_ram.sv */
// Generic simple dual-port RAM with registered read.
module pebu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/pebu_pipe.sv */
// Four-stage effect and blend arithmetic pipeline with output register.
module pebu_pipe import pebu_pkg::*; (
  input  logic             clk,
  input  pebu_stage_ld_t   ld,
  input  pebu_cfg_t        cfg,
  input  logic             in_opcode,
  input  logic [PIX_W-1:0] in_pixel,
  input  logic [PIX_W-1:0] in_dest_pixel,
  input  logic [CH_W-1:0]  tone_r,
  input  logic [CH_W-1:0]  tone_g,
  input  logic [CH_W-1:0]  tone_b,
  output logic [PIX_W-1:0] out_pixel,
  output logic             out_write_enable
);

  // stage 1
  logic             op1_r;
  logic [PIX_W-1:0] pix1_r, dst1_r;
  // stage 2
  logic             op2_r;
  logic [PIX_W-1:0] pix2_r, dst2_r, base2_r;
  logic [17:0]      gsum2_r;
  logic [15:0]      tprod2_r [3];
  logic [15:0]      eprod2_r;
  // stage 3
  logic             op3_r;
  logic [PIX_W-1:0] pix3_r, dst3_r, base3_r;
  logic [CH_W-1:0]  e3_r;
  logic [GREY_PROD_W-1:0] gprod3_r;
  // stage 4
  logic             op4_r;
  logic [PIX_W-1:0] pix4_r, dst4_r, base4_r;
  logic [CH_W-1:0]  e4_r, alpha4_r;
  logic [15:0]      bsum4_r [3];
  // output
  logic [PIX_W-1:0] out_pixel_r;
  logic             out_we_r;

  logic [17:0]      gsum_s1;
  logic [15:0]      tprod_s1 [3];
  logic [15:0]      eprod_s1;
  logic [CH_W-1:0]  sa_s1;
  logic [PIX_W-1:0] base_s1, base_s2, base_s3;
  logic [CH_W-1:0]  tq_s2 [3];
  logic [CH_W-1:0]  e_s2;
  logic [GREY_PROD_W-1:0] gprod_s2;
  logic [CH_W-1:0]  y_s3, inv_s3, alpha_s3;
  logic [8:0]       asum_s3;
  logic [15:0]      bsum_s3 [3];
  logic [PIX_W-1:0] res_s4;
  logic             we_s4;

  always_ff @(posedge clk) begin
    if (ld.s1) begin
      op1_r  <= in_opcode;
      pix1_r <= in_pixel;
      dst1_r <= in_dest_pixel;
    end
  end

  // stage 1: products, simple modes
  always_comb begin
    gsum_s1 = ({10'b0, pix1_r[7:0]} * GREY_WR) + ({10'b0, pix1_r[15:8]} * GREY_WG)
            + ({10'b0, pix1_r[23:16]} * GREY_WB);
    for (int k = 0; k < 3; k++) begin
      tprod_s1[k] = {8'b0, pix1_r[8*k +: 8]} * {8'b0, cfg.op_colour[8*k +: 8]};
    end
    sa_s1    = cfg.use_source_alpha ? pix1_r[31:24] : CH_MAX;
    eprod_s1 = {8'b0, sa_s1} * {8'b0, cfg.blend_alpha};
    case (cfg.mode)
      MODE_FILL:   base_s1 = cfg.op_colour;
      MODE_INVERT: base_s1 = {pix1_r[31:24], ~pix1_r[23:0]};
      MODE_TONE:   base_s1 = pack_px(tone_r, tone_g, tone_b, pix1_r[31:24]);
      default:     base_s1 = pix1_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld.s2) begin
      op2_r    <= op1_r;
      pix2_r   <= pix1_r;
      dst2_r   <= dst1_r;
      base2_r  <= base_s1;
      gsum2_r  <= gsum_s1;
      eprod2_r <= eprod_s1;
      for (int k = 0; k < 3; k++) begin
        tprod2_r[k] <= tprod_s1[k];
      end
    end
  end

  // stage 2: divisions by 255, grey reciprocal multiply
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      tq_s2[k] = div255(tprod2_r[k]);
    end
    e_s2     = div255(eprod2_r);
    gprod_s2 = {19'b0, gsum2_r} * {18'b0, GREY_RECIP};
    if (cfg.mode == MODE_TINT) begin
      base_s2 = pack_px(tq_s2[0], tq_s2[1], tq_s2[2], pix2_r[31:24]);
    end else begin
      base_s2 = base2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld.s3) begin
      op3_r    <= op2_r;
      pix3_r   <= pix2_r;
      dst3_r   <= dst2_r;
      base3_r  <= base_s2;
      e3_r     <= e_s2;
      gprod3_r <= gprod_s2;
    end
  end

  // stage 3: grey result, blend lane products
  always_comb begin
    y_s3   = gprod3_r[GREY_SHIFT +: CH_W];
    inv_s3 = CH_MAX - e3_r;
    for (int k = 0; k < 3; k++) begin
      bsum_s3[k] = ({8'b0, pix3_r[8*k +: 8]} * {8'b0, e3_r})
                 + ({8'b0, dst3_r[8*k +: 8]} * {8'b0, inv_s3});
    end
    asum_s3  = {1'b0, dst3_r[31:24]} + {1'b0, e3_r};
    alpha_s3 = asum_s3[8] ? CH_MAX : asum_s3[7:0];
    if (cfg.mode == MODE_GREY) begin
      base_s3 = pack_px(y_s3, y_s3, y_s3, pix3_r[31:24]);
    end else begin
      base_s3 = base3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld.s4) begin
      op4_r    <= op3_r;
      pix4_r   <= pix3_r;
      dst4_r   <= dst3_r;
      base4_r  <= base_s3;
      e4_r     <= e3_r;
      alpha4_r <= alpha_s3;
      for (int k = 0; k < 3; k++) begin
        bsum4_r[k] <= bsum_s3[k];
      end
    end
  end

  // stage 4: blend finish and final select
  always_comb begin
    res_s4 = base4_r;
    we_s4  = 1'b1;
    if (op4_r == OP_TABLE) begin
      res_s4 = '0;
      we_s4  = 1'b0;
    end else if (cfg.mode == MODE_BLEND) begin
      if (e4_r == '0) begin
        res_s4 = dst4_r;
        we_s4  = 1'b0;
      end else if (e4_r == CH_MAX) begin
        res_s4 = pix4_r;
      end else begin
        res_s4 = pack_px(div255(bsum4_r[0]), div255(bsum4_r[1]), div255(bsum4_r[2]),
                         alpha4_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld.so) begin
      out_pixel_r <= res_s4;
      out_we_r    <= we_s4;
    end
  end

  assign out_pixel        = out_pixel_r;
  assign out_write_enable = out_we_r;

endmodule

/* test/testbench.sv */
// Self-checking testbench for the pixel effect and blend unit: random and directed traffic.
module testbench;
  import pebu_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = REG_USE_SA + 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;
  localparam int IDLE_PCT = 19;

  typedef enum logic {XFER_ITEM, XFER_CFG} xfer_kind_t;

  typedef struct {
    xfer_kind_t           kind;
    logic                 opcode;
    logic [PIX_W-1:0]     pixel;
    logic [PIX_W-1:0]     dest_pixel;
    logic [TCH_W-1:0]     tch;
    logic [CH_W-1:0]      tix;
    logic [CH_W-1:0]      tval;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DAT_W-1:0] data;
  } xfer_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             we;
  } effect_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_opcode = OP_PIXEL;
  logic [PIX_W-1:0] in_pixel = '0;
  logic [PIX_W-1:0] in_dest_pixel = '0;
  logic [TCH_W-1:0] in_table_channel = '0;
  logic [CH_W-1:0] in_table_index = '0;
  logic [CH_W-1:0] in_table_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [PIX_W-1:0] out_pixel;
  logic out_write_enable;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  pixel_effect_and_blend_unit uut (.*);

  always #4 clk = ~clk;

  xfer_t   pending_q[$];
  effect_t expected_px_q[$];
  int      fails = 0;
  int      accepted_px = 0;
  bit      in_acc = 1'b0;
  bit      cfg_acc = 1'b0;

  // predictor state
  logic [2:0]       cur_mode = MODE_FILL;
  logic [PIX_W-1:0] cur_colour = '0;
  logic [CH_W-1:0]  cur_blend_a = CH_MAX;
  logic             cur_use_sa = 1'b1;
  logic [CH_W-1:0]  tone_mem [768];

  // generator view of the configuration and the loaded tone entries
  logic [2:0] gen_mode = MODE_FILL;
  bit         gen_loaded [768];

  function automatic effect_t compute_effect(input logic op, input logic [PIX_W-1:0] px,
                                             input logic [PIX_W-1:0] dpx,
                                             input logic [TCH_W-1:0] tch,
                                             input logic [CH_W-1:0] tix,
                                             input logic [CH_W-1:0] tval);
    effect_t     res;
    int unsigned sc [4];
    int unsigned dc [4];
    int unsigned oc [4];
    int unsigned sa, e, y;
    int          k;
    for (k = 0; k < 4; k++) begin
      sc[k] = 32'(px[8*k +: 8]);
      dc[k] = 32'(dpx[8*k +: 8]);
      oc[k] = sc[k];
    end
    res.pixel = px;
    res.we = 1'b1;
    if (op == OP_TABLE) begin
      if (tch <= TCH_BLUE) tone_mem[{tch, tix}] = tval;
      res.pixel = '0;
      res.we = 1'b0;
      return res;
    end
    case (cur_mode)
      MODE_FILL: res.pixel = cur_colour;
      MODE_INVERT: begin
        for (k = 0; k < 3; k++) oc[k] = 255 - sc[k];
      end
      MODE_GREY: begin
        y = (sc[0] * 299 + sc[1] * 587 + sc[2] * 114) / 1000;
        for (k = 0; k < 3; k++) oc[k] = y;
      end
      MODE_TINT: begin
        for (k = 0; k < 3; k++) oc[k] = sc[k] * cur_colour[8*k +: 8] / 255;
      end
      MODE_TONE: begin
        for (k = 0; k < 3; k++) oc[k] = 32'(tone_mem[k * 256 + sc[k]]);
      end
      MODE_BLEND: begin
        sa = cur_use_sa ? sc[3] : 255;
        e = sa * cur_blend_a / 255;
        if (e == 0) begin
          res.we = 1'b0;
          res.pixel = dpx;
        end else if (e != 255) begin
          for (k = 0; k < 3; k++) oc[k] = (sc[k] * e + dc[k] * (255 - e)) / 255;
          oc[3] = (dc[3] + e > 255) ? 255 : dc[3] + e;
        end
      end
      default: ;
    endcase
    if (cur_mode inside {MODE_INVERT, MODE_GREY, MODE_TINT, MODE_TONE} ||
        (cur_mode == MODE_BLEND && res.we && res.pixel == px && e != 255))
      res.pixel = {oc[3][7:0], oc[2][7:0], oc[1][7:0], oc[0][7:0]};
    return res;
  endfunction

  function automatic logic [CH_W-1:0] pick_byte();
    case ($urandom_range(0, 4))
      0: return 8'h00;
      1: return CH_MAX;
      default: return 8'($urandom);
    endcase
  endfunction

  // in tone mode every colour byte must hit an entry that has been loaded
  function automatic logic [PIX_W-1:0] pick_pixel();
    logic [CH_W-1:0] ch [3];
    int k;
    for (k = 0; k < 3; k++) begin
      ch[k] = pick_byte();
      if (gen_mode == MODE_TONE)
        while (!gen_loaded[k * 256 + ch[k]]) ch[k] = pick_byte();
    end
    return {pick_byte(), ch[2], ch[1], ch[0]};
  endfunction

  task automatic add_pixel(input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] dpx);
    xfer_t t;
    t.kind = XFER_ITEM;
    t.opcode = OP_PIXEL;
    t.pixel = px;
    t.dest_pixel = dpx;
    t.tch = TCH_W'($urandom);
    t.tix = 8'($urandom);
    t.tval = 8'($urandom);
    t.idx = '0;
    t.data = '0;
    pending_q.push_back(t);
  endtask

  task automatic add_load(input logic [TCH_W-1:0] ch, input logic [CH_W-1:0] ix,
                          input logic [CH_W-1:0] val);
    xfer_t t;
    t.kind = XFER_ITEM;
    t.opcode = OP_TABLE;
    t.pixel = $urandom;
    t.dest_pixel = $urandom;
    t.tch = ch;
    t.tix = ix;
    t.tval = val;
    t.idx = '0;
    t.data = '0;
    pending_q.push_back(t);
    if (ch <= TCH_BLUE) gen_loaded[{ch, ix}] = 1'b1;
  endtask

  task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    xfer_t t;
    t.kind = XFER_CFG;
    t.opcode = OP_PIXEL;
    t.pixel = '0;
    t.dest_pixel = '0;
    t.tch = '0;
    t.tix = '0;
    t.tval = '0;
    t.idx = idx;
    t.data = data;
    pending_q.push_back(t);
    if (idx == REG_MODE) gen_mode = data[2:0];
  endtask

  // driver: one transaction at a time per channel, config only once the pipe is empty
  always @(negedge clk) begin
    logic  nv, ncv;
    bit    quiet;
    xfer_t nxt;
    nv = in_valid;
    ncv = cfg_valid;
    quiet = accepted_px >= 150 && accepted_px < 260;
    if (in_acc) nv = 1'b0;
    if (cfg_acc) ncv = 1'b0;
    if (rst_n && !nv && !ncv && pending_q.size() > 0) begin
      if (pending_q[0].kind == XFER_ITEM) begin
        if (quiet || $urandom_range(0, 99) >= IDLE_PCT) begin
          nxt = pending_q.pop_front();
          in_opcode <= nxt.opcode;
          in_pixel <= nxt.pixel;
          in_dest_pixel <= nxt.dest_pixel;
          in_table_channel <= nxt.tch;
          in_table_index <= nxt.tix;
          in_table_value <= nxt.tval;
          nv = 1'b1;
        end
      end else if (expected_px_q.size() == 0) begin
        nxt = pending_q.pop_front();
        cfg_index <= nxt.idx;
        cfg_data <= nxt.data;
        ncv = 1'b1;
      end
    end
    in_valid <= nv;
    cfg_valid <= ncv;
    out_ready <= quiet || $urandom_range(0, 99) >= IDLE_PCT;
  end

  // monitor: predict on input transactions, compare on output transactions
  always @(posedge clk) begin
    effect_t exp_r;
    in_acc = in_valid && in_ready;
    cfg_acc = cfg_valid && cfg_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_px_q.size() == 0) begin
          $error("unexpected result: out_pixel %h, out_write_enable %b",
                 out_pixel, out_write_enable);
          fails++;
        end else begin
          exp_r = expected_px_q.pop_front();
          if (out_pixel !== exp_r.pixel) begin
            $error("out_pixel: expected %h, actual %h", exp_r.pixel, out_pixel);
            fails++;
          end
          if (out_write_enable !== exp_r.we) begin
            $error("out_write_enable: expected %b, actual %b", exp_r.we, out_write_enable);
            fails++;
          end
        end
      end
      if (cfg_acc) begin
        case (cfg_index)
          REG_MODE:      cur_mode = cfg_data[2:0];
          REG_OP_COLOUR: cur_colour = cfg_data;
          REG_BLEND_A:   cur_blend_a = cfg_data[7:0];
          REG_USE_SA:    cur_use_sa = cfg_data[0];
          default: ;
        endcase
      end
      if (in_acc) begin
        expected_px_q.push_back(compute_effect(in_opcode, in_pixel, in_dest_pixel,
                                               in_table_channel, in_table_index,
                                               in_table_value));
        accepted_px++;
      end
    end
  end

  initial begin
    #400000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int n_items, len, k, m;
    // directed: reset opacity settings first, blend copy / skip / mix
    add_cfg(REG_MODE, CFG_DAT_W'(MODE_BLEND));
    add_pixel(32'hFF123456, $urandom);
    add_pixel(32'h00ABCDEF, $urandom);
    add_pixel(32'h80FF0080, 32'h40102030);
    // tone entries at both ends of every channel; channel 3 load is dropped
    for (k = 0; k < 3; k++) begin
      add_load(TCH_W'(k), 8'h00, 8'($urandom));
      add_load(TCH_W'(k), CH_MAX, 8'($urandom));
    end
    add_load(2'd3, 8'h5A, 8'($urandom));
    add_cfg(REG_MODE, CFG_DAT_W'(MODE_FILL));
    add_cfg(REG_OP_COLOUR, 32'hFFFFFFFF);
    add_pixel($urandom, $urandom);
    add_cfg(REG_MODE, CFG_DAT_W'(MODE_INVERT));
    add_pixel(32'h00000000, $urandom);
    add_pixel(32'hFFFFFFFF, $urandom);
    add_cfg(REG_MODE, CFG_DAT_W'(MODE_GREY));
    add_pixel(32'h00FFFFFF, $urandom);
    add_pixel(32'hFF000000, $urandom);
    add_cfg(REG_MODE, CFG_DAT_W'(MODE_TINT));
    add_cfg(REG_OP_COLOUR, 32'h00FF8000);
    add_pixel(32'hFFFFFFFF, $urandom);
    add_cfg(REG_MODE, CFG_DAT_W'(MODE_TONE));
    add_pixel(32'hAB00FF00, $urandom);
    add_pixel(32'h12FF00FF, $urandom);
    add_cfg(REG_MODE, 32'd6);
    add_pixel($urandom, $urandom);
    add_cfg(REG_MODE, 32'd7);
    add_pixel($urandom, $urandom);
    // opaque source with zero, full and partial opacity; dest alpha saturates
    add_cfg(REG_MODE, CFG_DAT_W'(MODE_BLEND));
    add_cfg(REG_USE_SA, 32'd0);
    add_cfg(REG_BLEND_A, 32'd0);
    add_pixel($urandom, $urandom);
    add_cfg(REG_BLEND_A, 32'd255);
    add_pixel($urandom, $urandom);
    add_cfg(REG_BLEND_A, 32'd128);
    add_pixel($urandom, 32'hF0A0B0C0);
    add_cfg(REG_UNUSED_LO, $urandom);
    add_pixel($urandom, $urandom);

    n_items = 0;
    while (n_items < 360) begin
      if ($urandom_range(0, 1)) begin
        m = $urandom_range(0, 9);
        if (m > 7) m = (m == 8) ? MODE_TONE : MODE_BLEND;
        add_cfg(REG_MODE, CFG_DAT_W'(m));
      end
      if ($urandom_range(0, 1))
        add_cfg(REG_OP_COLOUR, {pick_byte(), pick_byte(), pick_byte(), pick_byte()});
      if ($urandom_range(0, 1)) add_cfg(REG_BLEND_A, CFG_DAT_W'(pick_byte()));
      if ($urandom_range(0, 1)) add_cfg(REG_USE_SA, CFG_DAT_W'($urandom_range(0, 1)));
      if ($urandom_range(0, 9) == 0)
        add_cfg(CFG_IDX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)), $urandom);
      len = $urandom_range(8, 40);
      for (k = 0; k < len; k++) begin
        if ($urandom_range(0, 4) == 0)
          add_load(TCH_W'($urandom_range(0, 3)), pick_byte(), 8'($urandom));
        else
          add_pixel(pick_pixel(), $urandom);
      end
      n_items += len;
    end

    repeat (4) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    while (pending_q.size() != 0 || in_valid || cfg_valid || expected_px_q.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (fails == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
